### rtl/efc_pkg.sv
// efc_pkg: shared types, codes and helper functions for the euler flux block
// no dependencies; imported by the top level
package efc_pkg;

    localparam int VAL_W  = 32;
    localparam int DEN_W  = 31;
    localparam int GAM_W  = 18;
    localparam int ND_W   = 2;
    localparam int DIR_W  = 2;
    localparam int PROD_W = 64;
    localparam int MD_QB  = 34;   // quotient bits resolved for flux divides
    localparam int NLANE  = 6;    // mom x, mom y, mom z, energy, ion, adv

    localparam int LANE_E   = 3;
    localparam int LANE_ION = 4;
    localparam int LANE_ADV = 5;

    localparam logic [GAM_W-1:0] GAMMA_RST = 18'd109227;
    localparam logic [ND_W-1:0]  ND_RST    = 2'd3;
    localparam logic [DIR_W-1:0] DIR_NONE  = 2'd3;

    localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_BAD_DIR  = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_GAMMA    = 1'b0,
        REG_NUM_DIMS = 1'b1
    } t_reg_idx;

    // per-item payload that rides along the kinetic energy divide
    typedef struct packed {
        t_status                   status;
        logic [DIR_W-1:0]          dir;
        logic [ND_W-1:0]           nd;
        logic [DEN_W-1:0]          den;
        logic signed [VAL_W-1:0]   gm1;
        logic signed [VAL_W-1:0]   mom_x;
        logic signed [VAL_W-1:0]   mom_y;
        logic signed [VAL_W-1:0]   mom_z;
        logic signed [VAL_W-1:0]   energy;
        logic signed [VAL_W-1:0]   ion;
        logic signed [VAL_W-1:0]   adv;
        logic signed [VAL_W-1:0]   mdir;
    } t_item;

    // what the output stage still needs after the flux divides
    typedef struct packed {
        t_status                   status;
        logic [DIR_W-1:0]          dir;
        logic [ND_W-1:0]           nd;
        logic signed [VAL_W-1:0]   pres;
        logic signed [VAL_W-1:0]   mdir;
        logic [NLANE-1:0]          neg;
    } t_tail;

    function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] x);
        logic [VAL_W-1:0] m;
        m = x[VAL_W-1] ? unsigned'(-x) : unsigned'(x);
        return m;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [36:0] x);
        logic signed [VAL_W-1:0] y;
        if (x > 37'sd2147483647) begin
            y = SAT_MAX;
        end else if (x < -37'sd2147483648) begin
            y = SAT_MIN;
        end else begin
            y = x[VAL_W-1:0];
        end
        return y;
    endfunction

endpackage

### rtl/efc_div.sv
// efc_div: pipelined unsigned restoring divider, one quotient bit per stage
// standalone; quotient above QB bits is flagged as overflow at entry
module efc_div #(
    parameter int NUM_W  = 64,
    parameter int DEN_BW = 31,
    parameter int QB     = 34
) (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_BW-1:0] i_den,
    output logic [QB-1:0]     o_quo,
    output logic              o_ovf
);

    localparam int TOP_W = NUM_W - QB;
    localparam int CMP_W = (TOP_W > DEN_BW) ? TOP_W : DEN_BW;

    logic [TOP_W-1:0]  top;
    logic              n_ovf;

    logic [DEN_BW-1:0] r_rem [QB];
    logic [QB-1:0]     r_bits [QB+1];
    logic [DEN_BW-1:0] r_dvs [QB];
    logic              r_ovf [QB+1];

    assign top   = i_num[NUM_W-1:QB];
    assign n_ovf = CMP_W'(top) >= CMP_W'(i_den);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DEN_BW'(top);
        r_bits[0] <= i_num[QB-1:0];
        r_dvs[0]  <= i_den;
        r_ovf[0]  <= n_ovf;
    end

    for (genvar g = 0; g < QB; g++) begin : g_step
        logic [DEN_BW:0] trial;
        logic            fit;

        assign trial = {r_rem[g], r_bits[g][QB-1]};
        assign fit   = trial >= {1'b0, r_dvs[g]};

        always_ff @(posedge i_clk) begin
            r_bits[g+1] <= {r_bits[g][QB-2:0], fit};
            r_ovf[g+1]  <= r_ovf[g];
        end

        if (g < QB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= fit ? DEN_BW'(trial - {1'b0, r_dvs[g]})
                                  : trial[DEN_BW-1:0];
                r_dvs[g+1] <= r_dvs[g];
            end
        end
    end

    assign o_quo = r_bits[QB];
    assign o_ovf = r_ovf[QB];

    // quotient bits resolved in order
endmodule

### rtl/efc_dly.sv
// efc_dly: fixed-depth delay line for a valid bit and a packed payload word
// standalone; keeps side data aligned with the divider pipelines
module efc_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_vld,
    output logic [W-1:0] o_data
);

    logic         r_vld  [DEPTH];
    logic [W-1:0] r_data [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int i = 1; i < DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_data[i] <= r_data[i-1];
        end
    end

    assign o_vld  = r_vld[DEPTH-1];
    assign o_data = r_data[DEPTH-1];

endmodule

### rtl/euler_flux_from_conserved.sv
// euler_flux_from_conserved: top level, euler flux of one cell's conserved state
// depends on efc_pkg, efc_div (pipelined divider) and efc_dly (delay line)
//
//  channel   direction  handshake                 word
//  -------   ---------  ------------------------  -----------------------------------
//  command   in         start high, busy low      density, momenta, energy, scalars, dir
//  result    out        o_done strobe, one cycle  seven fluxes and status
//  config    in         i_cfg_valid / o_cfg_ready register index and data
//
// fully pipelined: one word accepted every cycle while busy is low, no stalls on either side
// an accepted word passes stages 1 to 3, the kinetic energy divide, stages 4 to 7,
//   the flux divides and stage 8 before its result strobe
// synchronous active-low reset clears all valid bits; busy is high only around reset
// the receiver cannot stall, so the pipeline never holds and nothing is dropped
module euler_flux_from_conserved
    import efc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DEN_W-1:0]        i_density,
    input  logic signed [VAL_W-1:0] i_mom_x,
    input  logic signed [VAL_W-1:0] i_mom_y,
    input  logic signed [VAL_W-1:0] i_mom_z,
    input  logic signed [VAL_W-1:0] i_energy,
    input  logic signed [VAL_W-1:0] i_ion_scalar,
    input  logic signed [VAL_W-1:0] i_adv_scalar,
    input  logic [DIR_W-1:0]        i_direction,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_flux_mass,
    output logic signed [VAL_W-1:0] o_flux_mom_x,
    output logic signed [VAL_W-1:0] o_flux_mom_y,
    output logic signed [VAL_W-1:0] o_flux_mom_z,
    output logic signed [VAL_W-1:0] o_flux_energy,
    output logic signed [VAL_W-1:0] o_flux_ion,
    output logic signed [VAL_W-1:0] o_flux_adv,
    output logic [1:0]              o_status,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [0:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    // kinetic energy must be exact up to where pressure saturates for any gamma
    localparam int KE_QB  = (32 + FRAC_BITS > 62) ? 62 : 32 + FRAC_BITS;
    localparam int KE_W   = KE_QB + 1;
    localparam int DIFF_W = KE_QB + 2;
    localparam int DH_W   = KE_W - FRAC_BITS;
    localparam int PL_W   = FRAC_BITS + 31;
    localparam int KE_LAT = KE_QB + 1;
    localparam int MD_LAT = MD_QB + 1;
    localparam int LAT    = KE_QB + MD_QB + 10;
    localparam int ITEM_W = $bits(t_item);
    localparam int TAIL_W = $bits(t_tail);
    localparam logic signed [VAL_W-1:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    // ---------------- configuration and handshake ----------------
    logic [GAM_W-1:0] r_gamma;
    logic [ND_W-1:0]  r_nd;
    logic             r_cfg_ready;
    logic             r_busy;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma     <= GAMMA_RST;
            r_nd        <= ND_RST;
            r_cfg_ready <= 1'b0;
            r_busy      <= 1'b1;
        end else begin
            r_cfg_ready <= 1'b1;
            r_busy      <= 1'b0;
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_GAMMA:    r_gamma <= i_cfg_data[GAM_W-1:0];
                    REG_NUM_DIMS: r_nd    <= i_cfg_data[ND_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = r_cfg_ready;
    assign accept      = start && !r_busy;

    // ---------------- stage 1: capture word and config snapshot ----------------
    logic                    r1_vld;
    logic [DEN_W-1:0]        r1_den;
    logic signed [VAL_W-1:0] r1_mom [3];
    logic signed [VAL_W-1:0] r1_energy, r1_ion, r1_adv;
    logic [DIR_W-1:0]        r1_dir;
    logic [GAM_W-1:0]        r1_gamma;
    logic [ND_W-1:0]         r1_nd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_den    <= i_density;
        r1_mom[0] <= i_mom_x;
        r1_mom[1] <= i_mom_y;
        r1_mom[2] <= i_mom_z;
        r1_energy <= i_energy;
        r1_ion    <= i_ion_scalar;
        r1_adv    <= i_adv_scalar;
        r1_dir    <= i_direction;
        r1_gamma  <= r_gamma;
        r1_nd     <= r_nd;
    end

    // ---------------- stage 2: status, flux axis, momentum squares ----------------
    t_item        n2_item;
    logic [2:0]   act;
    logic [63:0]  n2_sq [3];
    logic         r2_vld;
    t_item        r2_item;
    logic [63:0]  r2_sq [3];

    always_comb begin
        logic [VAL_W-1:0] m;
        act[0] = r1_nd >= 2'd1;
        act[1] = r1_nd >= 2'd2;
        act[2] = r1_nd >= 2'd3;
        n2_item.dir    = r1_dir;
        n2_item.nd     = r1_nd;
        n2_item.den    = r1_den;
        n2_item.gm1    = $signed({14'd0, r1_gamma}) - ONE_Q;
        n2_item.mom_x  = r1_mom[0];
        n2_item.mom_y  = r1_mom[1];
        n2_item.mom_z  = r1_mom[2];
        n2_item.energy = r1_energy;
        n2_item.ion    = r1_ion;
        n2_item.adv    = r1_adv;
        case (r1_dir)
            2'd0:    n2_item.mdir = r1_mom[0];
            2'd1:    n2_item.mdir = r1_mom[1];
            2'd2:    n2_item.mdir = r1_mom[2];
            default: n2_item.mdir = '0;
        endcase
        // zero density wins over a bad axis
        if (r1_den == '0) begin
            n2_item.status = ST_ZERO_DEN;
        end else if (r1_dir >= r1_nd || r1_dir == DIR_NONE) begin
            n2_item.status = ST_BAD_DIR;
        end else begin
            n2_item.status = ST_OK;
        end
        for (int k = 0; k < 3; k++) begin
            m = mag32(r1_mom[k]);
            n2_sq[k] = act[k] ? (64'(m) * 64'(m)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_item <= n2_item;
        for (int k = 0; k < 3; k++) begin
            r2_sq[k] <= n2_sq[k];
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    logic        r3_vld;
    t_item       r3_item;
    logic [63:0] r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_item <= r2_item;
        r3_sum  <= r2_sq[0] + r2_sq[1] + r2_sq[2];
    end

    // ---------------- kinetic energy: (sumsq / 2) / density ----------------
    logic [KE_QB-1:0]  ke_q;
    logic              ke_ovf;
    logic              d1_vld;
    logic [ITEM_W-1:0] d1_bits;
    t_item             d1_item;

    efc_div #(
        .NUM_W  (63),
        .DEN_BW (DEN_W),
        .QB     (KE_QB)
    ) u_ke_div (
        .i_clk (i_clk),
        .i_num (r3_sum[63:1]),
        .i_den (r3_item.den),
        .o_quo (ke_q),
        .o_ovf (ke_ovf)
    );

    efc_dly #(
        .W     (ITEM_W),
        .DEPTH (KE_LAT)
    ) u_ke_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_data  (r3_item),
        .o_vld   (d1_vld),
        .o_data  (d1_bits)
    );

    assign d1_item = t_item'(d1_bits);

    // ---------------- stage 4: (energy - ke) * (gamma - 1), split product ----------------
    logic [KE_W-1:0]          ke_c;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        dm_full;
    logic [KE_W-1:0]          dm;
    logic [DH_W-1:0]          dh_full;
    logic [31:0]              dh;
    logic [FRAC_BITS-1:0]     dl;
    logic [VAL_W-1:0]         gm_full;
    logic [30:0]              gmag;
    logic                     n4_neg;

    logic                     r4_vld;
    t_item                    r4_item;
    logic [62:0]              r4_ph;
    logic [PL_W-1:0]          r4_pl;
    logic                     r4_neg;

    always_comb begin
        // an overflowed quotient is clamped where pressure saturates anyway
        ke_c    = ke_ovf ? (KE_W'(1) << KE_QB) : {1'b0, ke_q};
        diff    = DIFF_W'(d1_item.energy) - $signed({1'b0, ke_c});
        dm_full = diff[DIFF_W-1] ? unsigned'(-diff) : unsigned'(diff);
        dm      = dm_full[KE_W-1:0];
        dh_full = dm[KE_W-1:FRAC_BITS];
        dh      = (|dh_full[DH_W-1:31]) ? 32'h8000_0000 : dh_full[31:0];
        dl      = dm[FRAC_BITS-1:0];
        gm_full = mag32(d1_item.gm1);
        gmag    = gm_full[30:0];
        n4_neg  = diff[DIFF_W-1] ^ d1_item.gm1[VAL_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_item <= d1_item;
        r4_ph   <= 63'(dh) * 63'(gmag);
        r4_pl   <= PL_W'(dl) * PL_W'(gmag);
        r4_neg  <= n4_neg;
    end

    // ---------------- stage 5: pressure, saturated to 32 bits ----------------
    logic [63:0]             pm;
    logic signed [VAL_W-1:0] n5_pres;
    logic                    r5_vld;
    t_item                   r5_item;
    logic signed [VAL_W-1:0] r5_pres;

    always_comb begin
        pm = 64'(r4_ph) + 64'(r4_pl >> FRAC_BITS);
        if (|pm[63:31]) begin
            n5_pres = r4_neg ? SAT_MIN : SAT_MAX;
        end else begin
            n5_pres = r4_neg ? -$signed(pm[31:0]) : $signed(pm[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_item <= r4_item;
        r5_pres <= n5_pres;
    end

    // ---------------- stage 6: operand magnitudes and quotient signs ----------------
    logic signed [32:0] eps;
    logic [32:0]        n6_mag [NLANE];
    logic [NLANE-1:0]   n6_neg;
    t_tail              n6_tail;

    logic               r6_vld;
    logic [32:0]        r6_mag [NLANE];
    logic [VAL_W-1:0]   r6_mdmag;
    logic [DEN_W-1:0]   r6_den;
    t_tail              r6_tail;

    always_comb begin
        logic sd;
        sd  = r5_item.mdir[VAL_W-1];
        eps = 33'(r5_item.energy) + 33'(r5_pres);
        n6_mag[0]        = 33'(mag32(r5_item.mom_x));
        n6_mag[1]        = 33'(mag32(r5_item.mom_y));
        n6_mag[2]        = 33'(mag32(r5_item.mom_z));
        n6_mag[LANE_E]   = eps[32] ? unsigned'(-eps) : unsigned'(eps);
        n6_mag[LANE_ION] = 33'(mag32(r5_item.ion));
        n6_mag[LANE_ADV] = 33'(mag32(r5_item.adv));
        n6_neg[0]        = r5_item.mom_x[VAL_W-1] ^ sd;
        n6_neg[1]        = r5_item.mom_y[VAL_W-1] ^ sd;
        n6_neg[2]        = r5_item.mom_z[VAL_W-1] ^ sd;
        n6_neg[LANE_E]   = eps[32] ^ sd;
        n6_neg[LANE_ION] = r5_item.ion[VAL_W-1] ^ sd;
        n6_neg[LANE_ADV] = r5_item.adv[VAL_W-1] ^ sd;
        n6_tail.status = r5_item.status;
        n6_tail.dir    = r5_item.dir;
        n6_tail.nd     = r5_item.nd;
        n6_tail.pres   = r5_pres;
        n6_tail.mdir   = r5_item.mdir;
        n6_tail.neg    = n6_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NLANE; k++) begin
            r6_mag[k] <= n6_mag[k];
        end
        r6_mdmag <= mag32(r5_item.mdir);
        r6_den   <= r5_item.den;
        r6_tail  <= n6_tail;
    end

    // ---------------- stage 7: products with the axis momentum ----------------
    logic               r7_vld;
    logic [PROD_W-1:0]  r7_prod [NLANE];
    logic [DEN_W-1:0]   r7_den;
    t_tail              r7_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else begin
            r7_vld <= r6_vld;
        end
    end

    // products stay at or below 2^63, so 64 bits hold every product
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NLANE; k++) begin
            r7_prod[k] <= PROD_W'(65'(r6_mag[k]) * 65'(r6_mdmag));
        end
        r7_den  <= r6_den;
        r7_tail <= r6_tail;
    end

    // ---------------- flux divides, one lane per quotient ----------------
    logic [MD_QB-1:0]  md_q   [NLANE];
    logic              md_ovf [NLANE];
    logic              d2_vld;
    logic [TAIL_W-1:0] d2_bits;
    t_tail             d2_tail;

    for (genvar g = 0; g < NLANE; g++) begin : g_lane
        efc_div #(
            .NUM_W  (PROD_W),
            .DEN_BW (DEN_W),
            .QB     (MD_QB)
        ) u_md_div (
            .i_clk (i_clk),
            .i_num (r7_prod[g]),
            .i_den (r7_den),
            .o_quo (md_q[g]),
            .o_ovf (md_ovf[g])
        );
    end

    efc_dly #(
        .W     (TAIL_W),
        .DEPTH (MD_LAT)
    ) u_md_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_vld),
        .i_data  (r7_tail),
        .o_vld   (d2_vld),
        .o_data  (d2_bits)
    );

    assign d2_tail = t_tail'(d2_bits);

    // ---------------- stage 8: sign, pressure on the axis, saturate, mask ----------------
    logic signed [VAL_W-1:0] n8_flux [NLANE];
    logic [2:0]              act8;
    logic                    ok8;

    always_comb begin
        logic [MD_QB:0]     mv;
        logic signed [36:0] f;
        ok8     = d2_tail.status == ST_OK;
        act8[0] = d2_tail.nd >= 2'd1;
        act8[1] = d2_tail.nd >= 2'd2;
        act8[2] = d2_tail.nd >= 2'd3;
        for (int k = 0; k < NLANE; k++) begin
            // a quotient past the resolved range saturates the result anyway
            mv = md_ovf[k] ? ((MD_QB+1)'(1) << MD_QB) : {1'b0, md_q[k]};
            f  = $signed(37'(mv));
            if (d2_tail.neg[k]) begin
                f = -f;
            end
            if (k < 3 && d2_tail.dir == DIR_W'(k)) begin
                f = f + 37'(d2_tail.pres);
            end
            n8_flux[k] = sat32(f);
            if (!ok8 || (k < 3 && !act8[k % 3])) begin
                n8_flux[k] = '0;
            end
        end
    end

    logic                    r_done;
    logic signed [VAL_W-1:0] r_flux_mass;
    logic signed [VAL_W-1:0] r_flux [NLANE];
    logic [1:0]              r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flux_mass <= ok8 ? d2_tail.mdir : '0;
        for (int k = 0; k < NLANE; k++) begin
            r_flux[k] <= n8_flux[k];
        end
        r_status <= d2_tail.status;
    end

    assign o_done        = r_done;
    assign o_flux_mass   = r_flux_mass;
    assign o_flux_mom_x  = r_flux[0];
    assign o_flux_mom_y  = r_flux[1];
    assign o_flux_mom_z  = r_flux[2];
    assign o_flux_energy = r_flux[LANE_E];
    assign o_flux_ion    = r_flux[LANE_ION];
    assign o_flux_adv    = r_flux[LANE_ADV];
    assign o_status      = r_status;

`ifndef SYNTHESIS
    // every result strobe traces back to an accepted word
    a_done_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted word");

    // zero density status only for a word that really had zero density
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_ZERO_DEN) |-> $past(i_density == '0, LAT))
        else $error("zero density status on a nonzero density word");

    // error results carry no flux
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_flux_mass == '0 && o_flux_mom_x == '0 &&
            o_flux_mom_y == '0 && o_flux_mom_z == '0 && o_flux_energy == '0 &&
            o_flux_ion == '0 && o_flux_adv == '0))
        else $error("nonzero flux on an error result");

    // mass flux on the x axis is the x momentum of the word that went in
    a_mass_flux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK && $past(i_direction == 2'd0, LAT)) |->
            o_flux_mass == $past(i_mom_x, LAT))
        else $error("mass flux does not match x momentum");
`endif

endmodule
